>>> rtl/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned NumCells  = 8;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = $clog2(NumCells + 1);
  localparam int unsigned KindBits  = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned OutBits   = StatusBits + 3 * ValueBits + 2 + CountBits;
  localparam int unsigned OutBytes  = (OutBits + 7) / 8;

  localparam logic [KindBits-1:0] KindInsert = 2'd0;
  localparam logic [KindBits-1:0] KindRemove = 2'd1;
  localparam logic [KindBits-1:0] KindQuery  = 2'd2;

  localparam logic [StatusBits-1:0] StatusDone  = 2'd0;
  localparam logic [StatusBits-1:0] StatusFull  = 2'd1;
  localparam logic [StatusBits-1:0] StatusEmpty = 2'd2;

  typedef logic signed [ValueBits-1:0] value_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

>>> rtl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; every cell compares against the new value in parallel.
// A new transaction is accepted when no result is pending or the pending result is taken in the same cycle.
// Reset clears the entry count, the result valid flag and the cell contents.
module sorted_priority_queue_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // Fields from bit 0: value.
  input  logic [spq_pkg::ValueBits-1:0]         s_tdata_i,
  // Fields from bit 0: kind.
  input  logic [spq_pkg::KindBits-1:0]          s_tuser_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // Fields from bit 0: status, removed_value, head_value, tail_value, empty_flag,
  // full_flag, entry_count, then zero fill.
  output logic [8*spq_pkg::OutBytes-1:0]        m_tdata_o
);
  import spq_pkg::*;

  logic                  out_valid_q, out_valid_d;
  logic [StatusBits-1:0] status_q, status_d;
  value_t                removed_q, removed_d;
  logic [CountBits-1:0]  count_q, count_d;

  logic       accept;
  logic       is_full;
  logic       queue_empty;
  cell_ctrl_t ctrl;
  value_t     new_value;

  value_t               cell_value [NumCells];
  logic [NumCells-1:0]  cell_keep;
  value_t               cell_tail  [NumCells];
  value_t               head_value;
  value_t               tail_value;

  assign s_tready_o  = !out_valid_q || m_tready_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign is_full     = (count_q == CountBits'(NumCells));
  assign queue_empty = (count_q == '0);
  assign new_value   = s_tdata_i;

  always_comb begin
    ctrl      = '0;
    status_d  = status_q;
    removed_d = removed_q;
    count_d   = count_q;
    if (accept) begin
      status_d  = StatusDone;
      removed_d = '0;
      unique case (s_tuser_i)
        KindInsert: begin
          if (is_full) begin
            status_d = StatusFull;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + 1'b1;
          end
        end
        KindRemove: begin
          if (queue_empty) begin
            status_d = StatusEmpty;
          end else begin
            ctrl.remove = 1'b1;
            removed_d   = cell_value[0];
            count_d     = count_q - 1'b1;
          end
        end
        default: begin
          status_d = StatusDone;
        end
      endcase
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    value_t left_value;
    value_t right_value;
    logic   left_keep;

    if (i == 0) begin : g_first
      assign left_value = new_value;
      assign left_keep  = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == NumCells - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (new_value),
      .left_value_i (left_value),
      .left_keep_i  (left_keep),
      .right_value_i(right_value),
      .valid_i      (count_q > CountBits'(i)),
      .tail_i       (count_q == CountBits'(i + 1)),
      .value_o      (cell_value[i]),
      .keep_o       (cell_keep[i]),
      .tail_value_o (cell_tail[i])
    );
  end

  always_comb begin
    tail_value = '0;
    for (int unsigned i = 0; i < NumCells; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  assign head_value = queue_empty ? '0 : cell_value[0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = (8 * OutBytes)'({count_q, is_full, queue_empty,
                                       tail_value, head_value, removed_q, status_q});

endmodule

>>> rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a value and shifts with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::value_t    new_value_i,
  input  spq_pkg::value_t    left_value_i,
  input  logic               left_keep_i,
  input  spq_pkg::value_t    right_value_i,
  input  logic               valid_i,
  input  logic               tail_i,
  output spq_pkg::value_t    value_o,
  output logic               keep_o,
  output spq_pkg::value_t    tail_value_o
);
  import spq_pkg::*;

  value_t value_q;
  value_t value_d;

  // The cell keeps its entry on an insert when the entry is at least the new value.
  assign keep_o = valid_i && (value_q >= new_value_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (keep_o) begin
        value_d = value_q;
      end else if (left_keep_i) begin
        value_d = new_value_i;
      end else begin
        value_d = left_value_i;
      end
    end else if (ctrl_i.remove) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o      = value_q;
  assign tail_value_o = tail_i ? value_q : '0;

endmodule

>>> tb/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for the sorted priority queue unit: directed edge cases plus random traffic.
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam logic [KindBits-1:0] KindSpare = 2'd3;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RemovedLsb = StatusBits;
  localparam int unsigned HeadLsb = RemovedLsb + ValueBits;
  localparam int unsigned TailLsb = HeadLsb + ValueBits;
  localparam int unsigned EmptyBit = TailLsb + ValueBits;
  localparam int unsigned FullBit = EmptyBit + 1;
  localparam int unsigned CountLsb = FullBit + 1;

  typedef struct {
    logic [StatusBits-1:0] status;
    value_t                removed;
    value_t                head;
    value_t                tail;
    logic                  empty;
    logic                  full;
    logic [CountBits-1:0]  count;
  } queue_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic [ValueBits-1:0]       s_tdata = '0;
  logic [KindBits-1:0]        s_tuser = '0;
  logic                       m_tready = 1'b0;
  logic                       s_tready_o;
  logic                       m_tvalid_o;
  logic [8*OutBytes-1:0]      m_tdata_o;

  bit                         no_idle = 1'b0;
  int unsigned                mismatch_count = 0;
  queue_result_t              awaited_results[$];
  value_t                     model_entries[NumCells];
  int unsigned                model_count = 0;
  queue_result_t              got_result;
  queue_result_t              want_result;

  sorted_priority_queue_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic queue_result_t sorted_queue_step(logic [KindBits-1:0] kind, value_t val);
    queue_result_t r;
    int unsigned   pos;
    r.status  = StatusDone;
    r.removed = '0;
    case (kind)
      KindInsert: begin
        if (model_count >= NumCells) begin
          r.status = StatusFull;
        end else begin
          pos = 0;
          while (pos < model_count && model_entries[pos] >= val) pos++;
          for (int unsigned i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
          model_entries[pos] = val;
          model_count++;
        end
      end
      KindRemove: begin
        if (model_count == 0) begin
          r.status = StatusEmpty;
        end else begin
          r.removed = model_entries[0];
          for (int unsigned i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
          model_count--;
        end
      end
      default: begin
      end
    endcase
    r.head  = (model_count != 0) ? model_entries[0] : '0;
    r.tail  = (model_count != 0) ? model_entries[model_count-1] : '0;
    r.empty = (model_count == 0);
    r.full  = (model_count >= NumCells);
    r.count = model_count[CountBits-1:0];
    return r;
  endfunction

  function automatic value_t pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom;
    if (sel < 80) return value_t'($signed($urandom_range(8)) - 4);
    case ($urandom_range(3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic send_op(input logic [KindBits-1:0] kind, input value_t val);
    while (!no_idle && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= val;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    awaited_results.push_back(sorted_queue_step(kind, val));
  endtask

  task automatic check_field(input string name, input logic [ValueBits-1:0] want,
                             input logic [ValueBits-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    m_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready) begin
      got_result.status  = m_tdata_o[StatusBits-1:0];
      got_result.removed = m_tdata_o[RemovedLsb +: ValueBits];
      got_result.head    = m_tdata_o[HeadLsb +: ValueBits];
      got_result.tail    = m_tdata_o[TailLsb +: ValueBits];
      got_result.empty   = m_tdata_o[EmptyBit];
      got_result.full    = m_tdata_o[FullBit];
      got_result.count   = m_tdata_o[CountLsb +: CountBits];
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, m_tdata_o);
      end else begin
        want_result = awaited_results.pop_front();
        check_field("status", want_result.status, got_result.status);
        check_field("removed_value", want_result.removed, got_result.removed);
        check_field("head_value", want_result.head, got_result.head);
        check_field("tail_value", want_result.tail, got_result.tail);
        check_field("empty_flag", want_result.empty, got_result.empty);
        check_field("full_flag", want_result.full, got_result.full);
        check_field("entry_count", want_result.count, got_result.count);
      end
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("sorted_priority_queue_unit verification failed");
    $finish;
  end

  task automatic test_empty_queue();
    send_op(KindRemove, 32'h1234_5678);
    send_op(KindQuery, 32'hffff_ffff);
    send_op(KindSpare, 32'h8000_0000);
  endtask

  task automatic test_fill_and_reject();
    send_op(KindInsert, 32'h7fff_ffff);
    send_op(KindInsert, 32'h8000_0000);
    send_op(KindInsert, 32'h0000_0000);
    send_op(KindInsert, 32'hffff_ffff);
    send_op(KindInsert, 32'h0000_0005);
    send_op(KindInsert, 32'h0000_0005);
    send_op(KindInsert, 32'hffff_ffff);
    send_op(KindInsert, 32'h0000_0000);
    send_op(KindInsert, 32'h0000_0001);
    send_op(KindQuery, 32'h0000_0000);
    send_op(KindSpare, 32'h7fff_ffff);
  endtask

  task automatic test_drain_to_empty();
    repeat (NumCells + 1) send_op(KindRemove, $urandom);
  endtask

  task automatic test_random_mix(input int unsigned n_ops);
    int unsigned   phase;
    int unsigned   insert_pct;
    int unsigned   sel;
    logic [KindBits-1:0] kind;
    phase = 0;
    for (int unsigned i = 0; i < n_ops; i++) begin
      if (i % 12 == 0) phase = $urandom_range(2);
      insert_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 50;
      sel = $urandom_range(99);
      if (sel < 4) kind = KindSpare;
      else if (sel < 10) kind = KindQuery;
      else if ($urandom_range(99) < insert_pct) kind = KindInsert;
      else kind = KindRemove;
      send_op(kind, pick_value());
    end
  endtask

  task automatic test_back_to_back(input int unsigned n_ops);
    no_idle = 1'b1;
    test_random_mix(n_ops);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_and_reject();
    test_drain_to_empty();
    test_random_mix(800);
    test_back_to_back(200);
    test_random_mix(800);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_unit verification clean");
    end else begin
      $display("sorted_priority_queue_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sorted_priority_queue_unit.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_tb.sv
